FILE: rtl/prf_pkg.sv
// ----------------------------------------------------------------------------
// prf_pkg: shared types and constants of the page replacement unit
// Frame geometry, register indexes, the scan request that travels along the
// frame cells and the update command broadcast to them.
// ----------------------------------------------------------------------------
package prf_pkg;

    localparam int FRAMES     = 8;
    localparam int PAGE_BITS  = 16;
    localparam int AGE_BITS   = 16;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W      = $clog2(FRAMES + 1);
    localparam int OUT_IDX_W  = 3;
    localparam int CFG_FRAMES_W = 4;
    localparam int CFG_W      = 4;
    localparam int CFG_ADDR_W = 1;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_POLICY = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAMES = 1'd1;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    localparam logic [CFG_FRAMES_W-1:0] FRAMES_RESET = CFG_FRAMES_W'(FRAMES);
    localparam logic [AGE_BITS-1:0]     AGE_MAX      = '1;
    localparam logic [COUNT_BITS-1:0]   COUNT_MAX    = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    // Lookup request handed from cell to cell, one cell per cycle.
    typedef struct packed {
        logic                 valid;
        logic [PAGE_BITS-1:0] page;
        logic                 hit;
        logic [IDX_W-1:0]     hit_idx;
        logic [AGE_BITS-1:0]  best_age;
        logic [IDX_W-1:0]     best_idx;
        logic                 ptr_valid;
    } token_t;

    // Update command broadcast to every cell once the lookup has finished.
    typedef struct packed {
        logic                 en;
        logic                 hit;
        logic                 lru;
        logic [IDX_W-1:0]     idx;
        logic [PAGE_BITS-1:0] page;
    } upd_t;

endpackage

FILE: rtl/page_replacement_fifo_lru.sv
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru: FIFO / LRU page replacement unit
// Looks up one page reference per request in a row of frame cells and
// replaces a frame on a miss, in FIFO or least recently used order.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one page reference per request: s_tdata carries
//   the page number and s_tuser the clear flag, which empties every frame and
//   zeroes the pointer and fault count before the lookup.
//   The master channel returns one result per request: the fault flag on
//   m_tuser, and the frame index and saturating fault count on m_tdata.
//   The lookup request walks through the row of frame cells one cell a cycle;
//   a request is accepted only while the unit is idle, once the previous
//   lookup has finished, and its result is then held in an output register.
//   A new request is accepted while an earlier result still waits; it stalls
//   at the end of its lookup until the output register is free.
//   Reset selects FIFO mode with all eight frames in use and marks every
//   frame empty. The configuration port takes a write in any cycle and must
//   only be written while the unit is idle.
// ----------------------------------------------------------------------------
module page_replacement_fifo_lru (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [prf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [prf_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [prf_pkg::IN_TDATA_W-1:0]      s_tdata,  // [15:0] page
    input  logic                                s_tuser,  // [0] clear_first
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [prf_pkg::OUT_TDATA_W-1:0]     m_tdata,  // [2:0] frame_index, [18:3] fault_total
    output logic                                m_tuser   // [0] fault
);

    prf_pkg::state_t                state_reg, state_next;
    logic                           policy_reg;
    logic [prf_pkg::CFG_FRAMES_W-1:0] frames_reg;
    logic [prf_pkg::CNT_W-1:0]      used_reg, used_next, used_cfg;
    logic [prf_pkg::IDX_W-1:0]      ptr_reg, ptr_next;
    logic [prf_pkg::COUNT_BITS-1:0] count_reg, count_next, count_inc;
    logic                           launch_valid_reg, launch_valid_next;
    logic [prf_pkg::PAGE_BITS-1:0]  launch_page_reg;
    prf_pkg::token_t                launch_tok;
    prf_pkg::token_t                fin_reg;
    logic                           fin_load;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_fault_reg, out_fault_next;
    logic [prf_pkg::IDX_W-1:0]      out_idx_reg, out_idx_next;
    logic [prf_pkg::COUNT_BITS-1:0] out_count_reg, out_count_next;
    logic                           accept, clr;
    prf_pkg::upd_t                  upd;
    logic [prf_pkg::IDX_W-1:0]      victim;
    logic [prf_pkg::CNT_W-1:0]      victim_inc, ptr_wide;
    prf_pkg::token_t                chain [0:prf_pkg::FRAMES];
    logic [prf_pkg::FRAMES:0]       tok_valids;
    logic                           last_valid;

    assign accept   = s_tvalid && s_tready;
    assign clr      = accept && s_tuser;
    assign s_tready = (state_reg == prf_pkg::ST_IDLE);

    // Frame count from the register, held within 1 .. FRAMES.
    always_comb begin
        if (frames_reg == '0) begin
            used_cfg = prf_pkg::CNT_W'(1);
        end else if (frames_reg > prf_pkg::CFG_FRAMES_W'(prf_pkg::FRAMES)) begin
            used_cfg = prf_pkg::CNT_W'(prf_pkg::FRAMES);
        end else begin
            used_cfg = prf_pkg::CNT_W'(frames_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= prf_pkg::POLICY_FIFO;
            frames_reg <= prf_pkg::FRAMES_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                prf_pkg::REG_POLICY: policy_reg <= cfg_wdata[0];
                prf_pkg::REG_FRAMES: frames_reg <= cfg_wdata[prf_pkg::CFG_FRAMES_W-1:0];
                default: ;
            endcase
        end
    end

    // Lookup request enters the row from the launch register.
    always_comb begin
        launch_tok       = '0;
        launch_tok.valid = launch_valid_reg;
        launch_tok.page  = launch_page_reg;
    end

    assign chain[0] = launch_tok;

    genvar gi;
    generate
        for (gi = 0; gi < prf_pkg::FRAMES; gi++) begin : g_cell
            logic [prf_pkg::IDX_W-1:0] idx_c;
            assign idx_c = prf_pkg::IDX_W'(gi);
            prf_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (idx_c),
                .in_use   (prf_pkg::CNT_W'(idx_c) < used_reg),
                .is_ptr   (idx_c == ptr_reg),
                .clr      (clr),
                .upd      (upd),
                .tok_in   (chain[gi]),
                .tok_out  (chain[gi+1])
            );
        end
        for (gi = 0; gi <= prf_pkg::FRAMES; gi++) begin : g_vld
            assign tok_valids[gi] = chain[gi].valid;
        end
    endgenerate

    assign last_valid = chain[prf_pkg::FRAMES].valid;

    // Victim choice and pointer advance.
    assign victim     = (policy_reg == prf_pkg::POLICY_LRU && fin_reg.ptr_valid)
                        ? fin_reg.best_idx : ptr_reg;
    assign victim_inc = prf_pkg::CNT_W'(victim) + 1'b1;
    assign count_inc  = (count_reg != prf_pkg::COUNT_MAX) ? count_reg + 1'b1 : count_reg;
    assign ptr_wide   = prf_pkg::CNT_W'(ptr_reg);

    always_comb begin
        state_next        = state_reg;
        used_next         = used_reg;
        ptr_next          = ptr_reg;
        count_next        = count_reg;
        launch_valid_next = 1'b0;
        fin_load          = 1'b0;
        out_valid_next    = out_valid_reg && !m_tready;
        out_fault_next    = out_fault_reg;
        out_idx_next      = out_idx_reg;
        out_count_next    = out_count_reg;
        upd               = '0;
        upd.lru           = (policy_reg == prf_pkg::POLICY_LRU);
        upd.page          = fin_reg.page;
        upd.hit           = fin_reg.hit;
        upd.idx           = fin_reg.hit ? fin_reg.hit_idx : victim;

        case (state_reg)
            prf_pkg::ST_IDLE: begin
                if (accept) begin
                    used_next         = used_cfg;
                    launch_valid_next = 1'b1;
                    if (s_tuser || ptr_wide >= used_cfg) begin
                        ptr_next = '0;
                    end
                    if (s_tuser) begin
                        count_next = '0;
                    end
                    state_next = prf_pkg::ST_SCAN;
                end
            end
            prf_pkg::ST_SCAN: begin
                if (last_valid) begin
                    fin_load   = 1'b1;
                    state_next = prf_pkg::ST_COMMIT;
                end
            end
            prf_pkg::ST_COMMIT: begin
                if (!out_valid_reg || m_tready) begin
                    upd.en         = 1'b1;
                    out_valid_next = 1'b1;
                    out_fault_next = !fin_reg.hit;
                    if (fin_reg.hit) begin
                        out_idx_next   = fin_reg.hit_idx;
                        out_count_next = count_reg;
                    end else begin
                        out_idx_next   = victim;
                        out_count_next = count_inc;
                        count_next     = count_inc;
                        ptr_next       = (victim_inc >= used_reg) ? '0
                                         : prf_pkg::IDX_W'(victim_inc);
                    end
                    state_next = prf_pkg::ST_IDLE;
                end
            end
            default: state_next = prf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= prf_pkg::ST_IDLE;
            used_reg         <= prf_pkg::CNT_W'(prf_pkg::FRAMES);
            ptr_reg          <= '0;
            count_reg        <= '0;
            launch_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            used_reg         <= used_next;
            ptr_reg          <= ptr_next;
            count_reg        <= count_next;
            launch_valid_reg <= launch_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            launch_page_reg <= s_tdata[prf_pkg::PAGE_BITS-1:0];
        end
        if (fin_load) begin
            fin_reg <= chain[prf_pkg::FRAMES];
        end
        out_fault_reg <= out_fault_next;
        out_idx_reg   <= out_idx_next;
        out_count_reg <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_fault_reg;
    assign m_tdata  = {(prf_pkg::OUT_TDATA_W - prf_pkg::COUNT_BITS - prf_pkg::OUT_IDX_W)'(0),
                       out_count_reg, prf_pkg::OUT_IDX_W'(out_idx_reg)};

    // Only one lookup request is ever in flight along the row.
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_valids))
        else $error("more than one lookup request in the frame row");

    // A launched request reaches the end of the row after passing every frame cell.
    a_scan_len: assert property (@(posedge aclk) disable iff (!aresetn)
        launch_valid_reg |-> ##(prf_pkg::FRAMES) last_valid)
        else $error("lookup request lost in the frame row");

    // A new result is only presented together with a broadcast update.
    a_out_upd: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(upd.en))
        else $error("result presented without a frame update");

    // A reported fault always counts at least one fault.
    a_fault_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (out_count_reg != '0))
        else $error("fault reported with a zero fault count");

    // The reported frame is always one of the frames in use.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (prf_pkg::CNT_W'(out_idx_reg) < used_reg))
        else $error("reported frame outside the frames in use");

endmodule

FILE: rtl/prf_cell.sv
// ----------------------------------------------------------------------------
// prf_cell: one page frame
// Holds a frame's page, valid bit and age, adds its own view to the passing
// lookup request and applies the broadcast update.
// ----------------------------------------------------------------------------
module prf_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [prf_pkg::IDX_W-1:0] cell_idx,
    input  logic                      in_use,
    input  logic                      is_ptr,
    input  logic                      clr,
    input  prf_pkg::upd_t             upd,
    input  prf_pkg::token_t           tok_in,
    output prf_pkg::token_t           tok_out
);

    logic [prf_pkg::PAGE_BITS-1:0] page_reg;
    logic                          valid_reg, valid_next;
    logic [prf_pkg::AGE_BITS-1:0]  age_reg, age_next;
    prf_pkg::token_t               tok_reg, tok_next;
    logic                          sel;

    assign sel = upd.en && in_use && (upd.idx == cell_idx);

    always_comb begin
        tok_next = tok_in;
        if (in_use) begin
            if (valid_reg && (page_reg == tok_in.page) && !tok_in.hit) begin
                tok_next.hit     = 1'b1;
                tok_next.hit_idx = cell_idx;
            end
            if (is_ptr) begin
                tok_next.ptr_valid = valid_reg;
            end
            // The pointer's frame wins a tie; any other frame must be strictly older.
            if ((age_reg > tok_in.best_age) || (is_ptr && age_reg == tok_in.best_age)) begin
                tok_next.best_age = age_reg;
                tok_next.best_idx = cell_idx;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        age_next   = age_reg;
        if (clr) begin
            valid_next = 1'b0;
            age_next   = '0;
        end else if (upd.en && in_use) begin
            if (upd.lru) begin
                if (sel) begin
                    age_next = '0;
                end else if (age_reg != prf_pkg::AGE_MAX) begin
                    age_next = age_reg + 1'b1;
                end
            end
            if (sel && !upd.hit) begin
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            age_reg       <= '0;
            tok_reg.valid <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            age_reg       <= age_next;
            tok_reg.valid <= tok_next.valid;
        end
        tok_reg.page      <= tok_next.page;
        tok_reg.hit       <= tok_next.hit;
        tok_reg.hit_idx   <= tok_next.hit_idx;
        tok_reg.best_age  <= tok_next.best_age;
        tok_reg.best_idx  <= tok_next.best_idx;
        tok_reg.ptr_valid <= tok_next.ptr_valid;
        if (sel && !upd.hit) begin
            page_reg <= upd.page;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the FIFO / LRU page replacement unit
// Streams page references into the unit under a range of policy and frame
// count settings and compares every result with a cycle-free model of the
// frame table, replacement pointer, frame ages and saturating fault count.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE     = prf_pkg::FRAMES + 3;
    localparam int SET_SIZE   = 12;
    localparam int PHASES     = 14;
    localparam int PHASE_REFS = 125;

    // Policy and frame count of each random phase, phase 0 in the lowest bits.
    localparam logic [PHASES-1:0] PHASE_LRU = 14'b11_0101_0101_0101;
    localparam logic [PHASES*prf_pkg::CFG_W-1:0] PHASE_FRAMES = {
        4'd6, 4'd4, 4'd2, 4'd7, 4'd15, 4'd0, 4'd0,
        4'd15, 4'd5, 4'd3, 4'd1, 4'd1, 4'd8, 4'd8
    };

    typedef struct packed {
        logic [prf_pkg::PAGE_BITS-1:0] page;
        logic                          clear_first;
    } page_ref_t;

    typedef struct packed {
        logic                           fault;
        logic [prf_pkg::OUT_IDX_W-1:0]  frame_index;
        logic [prf_pkg::COUNT_BITS-1:0] fault_total;
    } lookup_t;

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [prf_pkg::CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [prf_pkg::CFG_W-1:0]       cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [prf_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;   // [15:0] page
    logic                            s_tuser   = 1'b0; // [0] clear_first
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [prf_pkg::OUT_TDATA_W-1:0] m_tdata;          // [2:0] frame_index, [18:3] fault_total
    logic                            m_tuser;          // [0] fault

    page_replacement_fifo_lru dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    page_ref_t page_refs_q[$];
    lookup_t   expected_results_q[$];
    int        n_errors  = 0;
    int        send_idle = 26;
    int        recv_idle = 54;

    // Model of the frame table and its configuration.
    logic                            lru_mode   = prf_pkg::POLICY_FIFO;
    logic [prf_pkg::CFG_W-1:0]       frames_cfg = prf_pkg::FRAMES_RESET;
    logic [prf_pkg::PAGE_BITS-1:0]   frame_pages  [prf_pkg::FRAMES];
    logic                            frame_loaded [prf_pkg::FRAMES];
    logic [prf_pkg::AGE_BITS-1:0]    frame_ages   [prf_pkg::FRAMES];
    int                              fill_slot    = 0;
    logic [prf_pkg::COUNT_BITS-1:0]  fault_count  = '0;

    logic [prf_pkg::PAGE_BITS-1:0]   working_set  [SET_SIZE];

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        n_errors++;
    endtask

    // The frame kept is zeroed; every other frame in use ages by one.
    function automatic void age_frames(input int used, input int keep);
        for (int k = 0; k < used; k++) begin
            if (k == keep)
                frame_ages[k] = '0;
            else if (frame_ages[k] != prf_pkg::AGE_MAX)
                frame_ages[k] = frame_ages[k] + 1'b1;
        end
    endfunction

    function automatic lookup_t replace_page(input logic [prf_pkg::PAGE_BITS-1:0] page,
                                             input logic clear_first);
        int used;
        int slot;
        int hit_at;
        int victim;
        logic [prf_pkg::AGE_BITS-1:0] oldest;
        lookup_t res;
        if (clear_first) begin
            for (int k = 0; k < prf_pkg::FRAMES; k++) begin
                frame_loaded[k] = 1'b0;
                frame_ages[k] = '0;
            end
            fill_slot = 0;
            fault_count = '0;
        end
        used = int'(frames_cfg);
        if (used < 1)
            used = 1;
        if (used > prf_pkg::FRAMES)
            used = prf_pkg::FRAMES;
        slot = (fill_slot >= used) ? 0 : fill_slot;
        hit_at = -1;
        for (int k = 0; k < used; k++) begin
            if (hit_at < 0 && frame_loaded[k] && frame_pages[k] == page)
                hit_at = k;
        end
        if (hit_at >= 0) begin
            if (lru_mode == prf_pkg::POLICY_LRU)
                age_frames(used, hit_at);
            fill_slot = slot;
            res.fault = 1'b0;
            res.frame_index = prf_pkg::OUT_IDX_W'(hit_at);
            res.fault_total = fault_count;
            return res;
        end
        // On a tie the pointer's frame stays the victim, then the lowest index.
        victim = slot;
        if (lru_mode == prf_pkg::POLICY_LRU && frame_loaded[slot]) begin
            oldest = frame_ages[slot];
            for (int k = 0; k < used; k++) begin
                if (frame_ages[k] > oldest) begin
                    oldest = frame_ages[k];
                    victim = k;
                end
            end
        end
        frame_pages[victim] = page;
        frame_loaded[victim] = 1'b1;
        if (lru_mode == prf_pkg::POLICY_LRU)
            age_frames(used, victim);
        fill_slot = (victim + 1 >= used) ? 0 : victim + 1;
        if (fault_count != prf_pkg::COUNT_MAX)
            fault_count = fault_count + 1'b1;
        res.fault = 1'b1;
        res.frame_index = prf_pkg::OUT_IDX_W'(victim);
        res.fault_total = fault_count;
        return res;
    endfunction

    // Request driver: lookups are predicted as the unit accepts them.
    always @(posedge aclk) begin : ref_driver
        page_ref_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results_q.push_back(replace_page(s_tdata, s_tuser));
            if (!s_tvalid || s_tready) begin
                if (page_refs_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    nxt = page_refs_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.page;
                    s_tuser <= nxt.clear_first;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        lookup_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
            if (m_tvalid && m_tready) begin
                if (expected_results_q.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = expected_results_q.pop_front();
                    if (m_tuser !== want.fault)
                        report_mismatch($sformatf("fault %b, expected %b",
                                                  m_tuser, want.fault));
                    if (m_tdata[2:0] !== want.frame_index)
                        report_mismatch($sformatf("frame_index %0d, expected %0d",
                                                  m_tdata[2:0], want.frame_index));
                    if (m_tdata[18:3] !== want.fault_total)
                        report_mismatch($sformatf("fault_total %0d, expected %0d",
                                                  m_tdata[18:3], want.fault_total));
                end
            end
        end
    end

    function automatic void push_ref(input logic [prf_pkg::PAGE_BITS-1:0] page,
                                     input logic clear_first);
        page_ref_t r;
        r.page = page;
        r.clear_first = clear_first;
        page_refs_q.push_back(r);
    endfunction

    // Checked at the falling edge so that the driver's updates have settled.
    task automatic wait_idle();
        while (page_refs_q.size() != 0 || s_tvalid || expected_results_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [prf_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [prf_pkg::CFG_W-1:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (addr == prf_pkg::REG_POLICY)
            lru_mode = data[0];
        else
            frames_cfg = data;
    endtask

    task automatic set_config(input logic policy, input logic [prf_pkg::CFG_W-1:0] frames);
        wait_idle();
        write_reg(prf_pkg::REG_POLICY, prf_pkg::CFG_W'(policy));
        write_reg(prf_pkg::REG_FRAMES, frames);
    endtask

    // Most requests come from a small set of pages so that hits and
    // replacements mix; a few are arbitrary pages or clears.
    task automatic queue_random_refs(input int count);
        int used;
        int pick;
        used = int'(frames_cfg);
        if (used < 1)
            used = 1;
        if (used > prf_pkg::FRAMES)
            used = prf_pkg::FRAMES;
        for (int k = 0; k < SET_SIZE; k++) begin
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 15))
                    0: working_set[k] = '0;
                    1: working_set[k] = '1;
                    default: working_set[k] = prf_pkg::PAGE_BITS'($urandom);
                endcase
            end
        end
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 88)
                push_ref(working_set[$urandom_range(0, used + 1)], pick < 3);
            else
                push_ref(prf_pkg::PAGE_BITS'($urandom), 1'b0);
        end
    endtask

    initial begin : stimulus
        for (int k = 0; k < prf_pkg::FRAMES; k++) begin
            frame_loaded[k] = 1'b0;
            frame_ages[k] = '0;
        end
        for (int k = 0; k < SET_SIZE; k++)
            working_set[k] = prf_pkg::PAGE_BITS'($urandom);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // FIFO with all frames: extreme pages, hits, and a clear.
        push_ref(16'h0000, 1'b0);
        push_ref(16'hFFFF, 1'b0);
        push_ref(16'h0000, 1'b0);
        push_ref(16'h5555, 1'b0);
        push_ref(16'hAAAA, 1'b0);
        push_ref(16'hFFFF, 1'b0);
        push_ref(16'hAAAA, 1'b1);
        push_ref(16'hAAAA, 1'b0);

        // LRU over three frames: empty fill, hits, then oldest-frame victims.
        set_config(prf_pkg::POLICY_LRU, 4'd3);
        push_ref(16'h0001, 1'b1);
        push_ref(16'h0002, 1'b0);
        push_ref(16'h0003, 1'b0);
        push_ref(16'h0001, 1'b0);
        push_ref(16'h0004, 1'b0);
        push_ref(16'h0003, 1'b0);
        push_ref(16'h0005, 1'b0);
        push_ref(16'h0002, 1'b0);

        // A page left in a frame outside the ones in use is loaded again
        // lower down; once all frames are back the lowest copy must hit.
        set_config(prf_pkg::POLICY_LRU, 4'd1);
        push_ref(16'h0003, 1'b0);
        set_config(prf_pkg::POLICY_LRU, 4'd8);
        push_ref(16'h0003, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            set_config(PHASE_LRU[p], PHASE_FRAMES[p*prf_pkg::CFG_W +: prf_pkg::CFG_W]);
            if (p < 5) begin
                send_idle = 26;
                recv_idle = 54;
            end else if (p < 10) begin
                send_idle = 54;
                recv_idle = 26;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (p == 5) begin
                // Hold back new requests until every result is in.
                queue_random_refs(PHASE_REFS / 2);
                wait_idle();
                queue_random_refs(PHASE_REFS - PHASE_REFS / 2);
            end else begin
                queue_random_refs(PHASE_REFS);
            end
        end

        set_config(prf_pkg::POLICY_LRU, 4'd8);
        queue_random_refs(40);

        wait_idle();
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/prf_pkg.sv
rtl/prf_cell.sv
rtl/page_replacement_fifo_lru.sv
tb/tb_top.sv
